// ===== src/trp_pkg.sv =====
// Shared types, constants and mode codes of the trajectory recorder.
`default_nettype none
package trp_pkg;

    // Keyframes per bank; the store holds two banks.
    localparam int MAX_KEYS    = 4096;
    localparam int IDX_W       = $clog2(MAX_KEYS);
    localparam int ADDR_W      = IDX_W + 1;
    localparam int DEPTH       = 2 * MAX_KEYS;
    localparam int CNT_W       = 13;
    localparam int MIN_GAP_US  = 33333;
    localparam int MIN_SPAN_US = 1000;

    // Shared divider widths.
    localparam int DIVD_W = 48;
    localparam int DIVS_W = 32;
    localparam int DCNT_W = $clog2(DIVD_W);

    typedef enum logic [2:0] {
        MODE_NEW_FRAME   = 3'd0,
        MODE_APPEND      = 3'd1,
        MODE_RESTART     = 3'd2,
        MODE_SAVE_BEST   = 3'd3,
        MODE_CLEAR       = 3'd4,
        MODE_PLAYBACK    = 3'd5,
        MODE_RESTART_MRK = 3'd6,
        MODE_UNUSED      = 3'd7
    } mode_t;

    // One stored keyframe.
    typedef struct packed {
        logic [15:0] heading;
        logic [31:0] z;
        logic [31:0] x;
        logic [31:0] tstamp;
    } key_t;

    // Divider request and response.
    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIVD_W-1:0] quotient;
        logic [DIVS_W-1:0] remainder;
    } div_rsp_t;

endpackage
`default_nettype wire

// ===== src/trp_divider.sv =====
// Unsigned restoring divider, one quotient bit per cycle.
`default_nettype none
module trp_divider (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire trp_pkg::div_req_t req,
    output trp_pkg::div_rsp_t   rsp
);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [trp_pkg::DCNT_W-1:0] cnt_reg, cnt_next;
    logic [trp_pkg::DIVD_W-1:0] q_reg, q_next;
    logic [trp_pkg::DIVS_W-1:0] r_reg, r_next;
    logic [trp_pkg::DIVS_W-1:0] d_reg, d_next;
    logic [trp_pkg::DIVS_W:0]   shifted;
    logic                       ge;

    // One shift and trial subtract per cycle.
    always_comb
    begin
        shifted   = {r_reg, q_reg[trp_pkg::DIVD_W-1]};
        ge        = shifted >= {1'b0, d_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = trp_pkg::DCNT_W'(trp_pkg::DIVD_W - 1);
            q_next    = req.dividend;
            r_next    = '0;
            d_next    = req.divisor;
        end
        else if (busy_reg)
        begin
            r_next = ge ? trp_pkg::DIVS_W'(shifted - {1'b0, d_reg})
                        : shifted[trp_pkg::DIVS_W-1:0];
            q_next = {q_reg[trp_pkg::DIVD_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = q_reg;
    assign rsp.remainder = r_reg;

    // A result never appears while the unit still iterates.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");

    // A start always leads into the busy phase.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> busy_reg)
        else $error("divider did not start");

    // The remainder stays below a nonzero divisor after completion.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && d_reg != '0) |-> (r_reg < d_reg))
        else $error("divider remainder out of range");

endmodule
`default_nettype wire

// ===== src/trajectory_recorder_playback_core.sv =====
// Top level: keyframe store, sequencer, shared multiplier and divider.
//
// Input items arrive on the s_ group and one result item per input leaves on
// the m_ group; an item moves when tvalid and tready are both high.
// s_tready is high only while the sequencer is idle, so one item is worked
// on at a time. Path of each item from accept to the result register:
//   new_frame, restart, restart marker, save_best, clear, unused code: direct.
//   append: one read of the previous keyframe, then the write.
//   playback with no valid pose: direct.
//   playback: a pass of the shared divider (lap time modulo the best lap),
//   then the search over the keyframe memory at one read per cycle, the
//   reads of the upper and lower keys, a second divider pass for the blend
//   weight, and the blend.
// The pose is blended on one shared multiplier in three steps.
// Reset clears counts, best lap, bank select and the frame flag; the keyframe
// memory is not cleared, and results only ever use written entries.
// The result sits in an output register; when the receiver stalls, the
// finished item waits there, and the next item may already be accepted and
// worked on until its own result needs that register.
`default_nettype none
module trajectory_recorder_playback_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // mode[2:0], lap_time_us[34:3], pos_x[66:35], pos_z[98:67],
    // heading[114:99], force_sample[115], lap_active[116], zero pad
    input  wire logic [119:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // pose_valid[0], ghost_x[32:1], ghost_z[64:33], ghost_heading[80:65],
    // recorded_count[93:81], stored_count[106:94], zero pad
    output logic [111:0]      m_tdata
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_APP, ST_APP_CHK, ST_MOD, ST_SRCH, ST_HI, ST_LO,
        ST_SPAN, ST_ALPHA, ST_BX, ST_BZ, ST_BH, ST_BF, ST_DONE
    } state_t;

    state_t                      state_reg;
    logic [trp_pkg::CNT_W-1:0]   live_cnt_reg, best_cnt_reg;
    logic [31:0]                 best_lap_reg;
    logic                        best_bank_reg, frame_reg;
    logic                        m_valid_reg;
    logic [111:0]                m_data_reg;

    // Latched item fields.
    logic [31:0]                 t_reg, x_reg, z_reg;
    logic [15:0]                 h_reg;
    logic                        force_reg, neg_reg;

    // Playback working registers.
    logic [trp_pkg::CNT_W-1:0]   u_reg;
    logic signed [32:0]          p_reg;
    trp_pkg::key_t               hi_reg, lo_reg;
    logic [16:0]                 alpha_reg;
    logic signed [50:0]          prod_reg;
    logic [31:0]                 gx_reg, gz_reg;
    logic [15:0]                 gh_reg;
    logic                        pv_reg;

    // Keyframe memory.
    trp_pkg::key_t               mem [trp_pkg::DEPTH];
    trp_pkg::key_t               rd_q;
    logic [trp_pkg::ADDR_W-1:0]  rd_addr, wr_addr;
    logic                        we;
    trp_pkg::key_t               wr_data;

    trp_pkg::div_req_t           dreq;
    trp_pkg::div_rsp_t           drsp;

    logic                        accept, live_bank, out_free, take, cont, pb_ok;
    logic [trp_pkg::CNT_W-1:0]   prev_idx, u_inc, u_dec;
    logic signed [32:0]          gap, span;
    logic signed [33:0]          num_raw;
    logic [31:0]                 num, t_in, mag;
    logic signed [32:0]          mul_a, p_val;
    logic signed [50:0]          mul_p;

    trp_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    // Blend: a + floor((prod + 32768) / 65536), kept to 32 bits.
    function automatic logic [31:0] finish(input logic [31:0] a,
                                           input logic signed [50:0] prod);
        logic signed [50:0] sum;
        logic signed [50:0] r;
        sum = prod + 51'sd32768;
        r   = (sum >>> 16) + 51'(signed'(a));
        return r[31:0];
    endfunction

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign live_bank = ~best_bank_reg;
    assign out_free  = !m_valid_reg || m_tready;
    assign t_in      = s_tdata[34:3];
    assign mag       = t_in[31] ? 32'(-t_in) : t_in;
    assign pb_ok     = (best_cnt_reg >= trp_pkg::CNT_W'(2)) &&
                       ($signed(best_lap_reg) > 32'sd0) && s_tdata[116];
    assign prev_idx  = live_cnt_reg - 1'b1;
    assign u_inc     = u_reg + 1'b1;
    assign u_dec     = u_reg - 1'b1;

    // Append spacing and acceptance.
    assign gap  = $signed({t_reg[31], t_reg}) - $signed({1'b0, rd_q.tstamp});
    assign take = (live_cnt_reg < trp_pkg::CNT_W'(trp_pkg::MAX_KEYS)) &&
                  (force_reg || (!frame_reg &&
                   (live_cnt_reg == '0 || gap >= 33'(trp_pkg::MIN_GAP_US))));

    // Search continues while the upper key is still earlier than the phase and a later key remains.
    assign cont = (u_reg < best_cnt_reg - 1'b1) &&
                  ($signed({1'b0, rd_q.tstamp}) < p_reg);

    // Span and clamped numerator of the blend weight.
    always_comb
    begin
        span    = $signed({1'b0, hi_reg.tstamp}) - $signed({1'b0, lo_reg.tstamp});
        if (span < 33'(trp_pkg::MIN_SPAN_US))
        begin
            span = 33'(trp_pkg::MIN_SPAN_US);
        end
        num_raw = 34'(p_reg) - $signed({2'b00, lo_reg.tstamp});
        if (num_raw < 34'sd0)
        begin
            num = '0;
        end
        else if (num_raw > 34'(span))
        begin
            num = span[31:0];
        end
        else
        begin
            num = num_raw[31:0];
        end
    end

    // Signed phase from the magnitude remainder.
    assign p_val = neg_reg ? -$signed({1'b0, drsp.remainder})
                           : $signed({1'b0, drsp.remainder});

    // Shared multiplier operand selection.
    always_comb
    begin
        case (state_reg)
            ST_BX:   mul_a = $signed({hi_reg.x[31], hi_reg.x}) -
                             $signed({lo_reg.x[31], lo_reg.x});
            ST_BZ:   mul_a = $signed({hi_reg.z[31], hi_reg.z}) -
                             $signed({lo_reg.z[31], lo_reg.z});
            ST_BH:   mul_a = 33'(signed'(16'(hi_reg.heading - lo_reg.heading)));
            default: mul_a = '0;
        endcase
    end
    assign mul_p = 51'(mul_a * $signed({1'b0, alpha_reg}));

    // Divider requests: phase modulo, then blend weight.
    always_comb
    begin
        dreq.start    = 1'b0;
        dreq.dividend = {16'b0, mag};
        dreq.divisor  = best_lap_reg;
        if (accept && trp_pkg::mode_t'(s_tdata[2:0]) == trp_pkg::MODE_PLAYBACK && pb_ok)
        begin
            dreq.start = 1'b1;
        end
        else if (state_reg == ST_SPAN)
        begin
            dreq.start    = 1'b1;
            dreq.dividend = {num, 16'b0};
            dreq.divisor  = span[31:0];
        end
    end

    // Memory address selection; the lower key is read while the upper one is held.
    always_comb
    begin
        case (state_reg)
            ST_APP:  rd_addr = {live_bank, prev_idx[trp_pkg::IDX_W-1:0]};
            ST_MOD:  rd_addr = {best_bank_reg, trp_pkg::IDX_W'(1)};
            ST_SRCH: rd_addr = cont ? {best_bank_reg, u_inc[trp_pkg::IDX_W-1:0]}
                                    : {best_bank_reg, u_dec[trp_pkg::IDX_W-1:0]};
            ST_HI:   rd_addr = {best_bank_reg, u_dec[trp_pkg::IDX_W-1:0]};
            default: rd_addr = {best_bank_reg, u_reg[trp_pkg::IDX_W-1:0]};
        endcase
        we              = (state_reg == ST_APP_CHK) && take;
        wr_addr         = {live_bank, live_cnt_reg[trp_pkg::IDX_W-1:0]};
        wr_data.tstamp  = t_reg[31] ? 32'd0 : t_reg;
        wr_data.x       = x_reg;
        wr_data.z       = z_reg;
        wr_data.heading = h_reg;
    end

    // Keyframe memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_q <= mem[rd_addr];
    end

    // Sequencer with state, counts and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            live_cnt_reg  <= '0;
            best_cnt_reg  <= '0;
            best_lap_reg  <= '0;
            best_bank_reg <= 1'b0;
            frame_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            if (m_valid_reg && m_tready && state_reg != ST_DONE)
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        t_reg     <= t_in;
                        x_reg     <= s_tdata[66:35];
                        z_reg     <= s_tdata[98:67];
                        h_reg     <= s_tdata[114:99];
                        force_reg <= s_tdata[115];
                        neg_reg   <= t_in[31];
                        u_reg     <= trp_pkg::CNT_W'(1);
                        pv_reg    <= 1'b0;
                        gx_reg    <= '0;
                        gz_reg    <= '0;
                        gh_reg    <= '0;
                        state_reg <= ST_DONE;
                        case (trp_pkg::mode_t'(s_tdata[2:0]))
                            trp_pkg::MODE_NEW_FRAME: frame_reg <= 1'b0;
                            trp_pkg::MODE_APPEND:    state_reg <= ST_APP;
                            trp_pkg::MODE_RESTART:   live_cnt_reg <= '0;
                            trp_pkg::MODE_SAVE_BEST:
                            begin
                                best_bank_reg <= live_bank;
                                best_cnt_reg  <= live_cnt_reg;
                                best_lap_reg  <= t_in;
                                live_cnt_reg  <= '0;
                            end
                            trp_pkg::MODE_CLEAR:
                            begin
                                live_cnt_reg <= '0;
                                best_cnt_reg <= '0;
                                best_lap_reg <= '0;
                                frame_reg    <= 1'b1;
                            end
                            trp_pkg::MODE_PLAYBACK:
                            begin
                                if (pb_ok)
                                begin
                                    state_reg <= ST_MOD;
                                end
                            end
                            trp_pkg::MODE_RESTART_MRK:
                            begin
                                live_cnt_reg <= '0;
                                frame_reg    <= 1'b1;
                            end
                            default: state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_APP:     state_reg <= ST_APP_CHK;
                ST_APP_CHK:
                begin
                    if (take)
                    begin
                        live_cnt_reg <= live_cnt_reg + 1'b1;
                        frame_reg    <= 1'b1;
                    end
                    state_reg <= ST_DONE;
                end
                ST_MOD:
                begin
                    if (drsp.done)
                    begin
                        p_reg     <= p_val;
                        state_reg <= ST_SRCH;
                    end
                end
                ST_SRCH:
                begin
                    if (cont)
                    begin
                        u_reg <= u_inc;
                    end
                    else
                    begin
                        hi_reg    <= rd_q;
                        state_reg <= ST_HI;
                    end
                end
                ST_HI:
                begin
                    state_reg <= ST_LO;
                end
                ST_LO:
                begin
                    lo_reg    <= rd_q;
                    state_reg <= ST_SPAN;
                end
                ST_SPAN:    state_reg <= ST_ALPHA;
                ST_ALPHA:
                begin
                    if (drsp.done)
                    begin
                        alpha_reg <= drsp.quotient[16:0];
                        state_reg <= ST_BX;
                    end
                end
                ST_BX:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_BZ;
                end
                ST_BZ:
                begin
                    gx_reg    <= finish(lo_reg.x, prod_reg);
                    prod_reg  <= mul_p;
                    state_reg <= ST_BH;
                end
                ST_BH:
                begin
                    gz_reg    <= finish(lo_reg.z, prod_reg);
                    prod_reg  <= mul_p;
                    state_reg <= ST_BF;
                end
                ST_BF:
                begin
                    gh_reg    <= 16'(finish({16'b0, lo_reg.heading}, prod_reg));
                    pv_reg    <= 1'b1;
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {5'b0, best_cnt_reg, live_cnt_reg, gh_reg,
                                        gz_reg, gx_reg, pv_reg};
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Counts never exceed one bank.
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_cnt_reg <= trp_pkg::CNT_W'(trp_pkg::MAX_KEYS))
        else $error("live count beyond bank size");

    a_best_bound: assert property (@(posedge clk) disable iff (!rst_n)
        best_cnt_reg <= trp_pkg::CNT_W'(trp_pkg::MAX_KEYS))
        else $error("best count beyond bank size");

    // The search index stays inside the stored best run.
    a_search_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SRCH) |-> (u_reg >= trp_pkg::CNT_W'(1) && u_reg < best_cnt_reg))
        else $error("search index outside best run");

    // The divider is idle whenever a new item may be accepted.
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !drsp.busy)
        else $error("divider busy while idle");

endmodule
`default_nettype wire
